FILE: hdl/gbr_pkg.sv
package gbr_pkg;

  localparam int unsigned WIN    = 7;
  localparam int unsigned HALF   = 3;
  localparam int unsigned PIX_W  = 8;
  localparam int unsigned COEF_W = 16;
  localparam int unsigned ROW_W  = 12;
  localparam int unsigned WT_W   = 19;
  localparam int unsigned VSUM_W = 27;
  localparam int unsigned ACC_W  = 46;
  localparam int unsigned FRAC_W = 32;

  typedef enum logic [2:0] {
    CFG_FRAME_WIDTH  = 3'd0,
    CFG_FRAME_HEIGHT = 3'd1,
    CFG_COEF_CENTER  = 3'd2,
    CFG_COEF_ONE     = 3'd3,
    CFG_COEF_TWO     = 3'd4,
    CFG_COEF_THREE   = 3'd5
  } cfg_idx_e;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_WGT,
    ST_ISSUE,
    ST_WAIT
  } state_e;

  typedef struct packed {
    logic              wclr;
    logic              wadd;
    logic [COEF_W-1:0] wval;
    logic              we;
    logic [PIX_W-1:0]  wdata;
  } cell_ctl_t;

  // row index mod 7: octal digits sum, then fold
  function automatic logic [2:0] mod7(input logic [ROW_W-1:0] v);
    logic [4:0] s;
    logic [3:0] t;
    s = 5'(v[2:0]) + 5'(v[5:3]) + 5'(v[8:6]) + 5'(v[11:9]);
    t = 4'(s[2:0]) + 4'(s[4:3]);
    if (t >= 4'd7) begin
      t = t - 4'd7;
    end
    return t[2:0];
  endfunction

  // distance of window tap k from the center
  function automatic logic [1:0] tap_ofs(input logic [2:0] k);
    logic [2:0] d;
    if (k < 3'(HALF)) begin
      d = 3'(HALF) - k;
    end else begin
      d = k - 3'(HALF);
    end
    return d[1:0];
  endfunction

endpackage

FILE: hdl/gbr_ram.sv
module gbr_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 1024,
  localparam int unsigned AW = $clog2(DEPTH)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

FILE: hdl/gbr_cell.sv
module gbr_cell import gbr_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024,
  localparam int unsigned CW = $clog2(MAX_WIDTH)
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  cell_ctl_t         ctl_i,
  input  logic [CW-1:0]     waddr_i,
  input  logic              vld_i,
  input  logic [CW-1:0]     addr_i,
  input  logic [VSUM_W-1:0] psum_i,
  output logic              vld_o,
  output logic [CW-1:0]     addr_o,
  output logic [VSUM_W-1:0] psum_o
);

  logic [WT_W-1:0]   wt_q;
  logic              vld_q;
  logic [CW-1:0]     addr_q;
  logic [VSUM_W-1:0] psum_q;
  logic [PIX_W-1:0]  rdata;

  gbr_ram #(
    .WIDTH(PIX_W),
    .DEPTH(MAX_WIDTH)
  ) u_line (
    .clk_i  (clk_i),
    .we_i   (ctl_i.we),
    .waddr_i(waddr_i),
    .wdata_i(ctl_i.wdata),
    .re_i   (vld_i),
    .raddr_i(addr_i),
    .rdata_o(rdata)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= 1'b0;
      wt_q  <= '0;
    end else begin
      vld_q <= vld_i;
      if (ctl_i.wclr) begin
        wt_q <= '0;
      end else if (ctl_i.wadd) begin
        wt_q <= wt_q + WT_W'(ctl_i.wval);
      end
    end
  end

  // pass the sum through where this row has no weight
  always_ff @(posedge clk_i) begin
    addr_q <= addr_i;
    if (vld_q) begin
      psum_q <= (wt_q == '0) ? psum_i : psum_i + VSUM_W'(VSUM_W'(rdata) * VSUM_W'(wt_q));
    end
  end

  assign vld_o  = vld_q;
  assign addr_o = addr_q;
  assign psum_o = psum_q;

endmodule

FILE: hdl/gbr_hacc.sv
module gbr_hacc import gbr_pkg::*; (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   vld_i,
  input  logic [VSUM_W-1:0]      vsum_i,
  input  logic [3:0][COEF_W-1:0] coef_i,
  output logic                   res_vld_o,
  output logic [PIX_W-1:0]       res_o
);

  localparam int unsigned PROD_W = VSUM_W + COEF_W;

  logic              vin_q;
  logic [2:0]        cnt_q;
  logic [PROD_W-1:0] prod_q;
  logic              pv_q;
  logic              plast_q;
  logic [ACC_W-1:0]  acc_q;
  logic [ACC_W-1:0]  sum;
  logic              res_vld_q;
  logic [PIX_W-1:0]  res_q;

  assign sum = acc_q + ACC_W'(prod_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vin_q     <= 1'b0;
      cnt_q     <= '0;
      pv_q      <= 1'b0;
      plast_q   <= 1'b0;
      acc_q     <= '0;
      res_vld_q <= 1'b0;
    end else begin
      vin_q     <= vld_i;
      pv_q      <= vin_q;
      plast_q   <= vin_q && (cnt_q == 3'(WIN - 1));
      res_vld_q <= pv_q && plast_q;
      if (vin_q) begin
        cnt_q <= (cnt_q == 3'(WIN - 1)) ? 3'd0 : cnt_q + 3'd1;
      end
      if (pv_q) begin
        acc_q <= plast_q ? '0 : sum;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (vin_q) begin
      prod_q <= PROD_W'(vsum_i) * PROD_W'(coef_i[tap_ofs(cnt_q)]);
    end
    if (pv_q && plast_q) begin
      res_q <= (|sum[ACC_W-1:FRAC_W+PIX_W]) ? '1 : sum[FRAC_W+PIX_W-1:FRAC_W];
    end
  end

  assign res_vld_o = res_vld_q;
  assign res_o     = res_q;

endmodule

FILE: hdl/gaussian_blur_7x7_reflect_top.sv
// 7x7 Gaussian blur of an 8-bit grayscale frame, mirrored borders.
// Slave stream: one word per pixel in row-major order; tuser high marks a
// flush word, which drains the last three output rows one pixel per word.
// Master stream: blurred pixels in row-major order, three rows and three
// columns behind the input; tlast marks the final pixel of the frame.
// Config channel: write frame geometry and the four Q0.16 weights while idle.
// A pixel word that completes output is followed by the weight setup, the
// seven column reads through the row of line buffer cells and the
// horizontal multiply-add before the result reaches the output register;
// the last pixel of a row gives four results, each with its own column reads.
// Words that give no result leave the block idle; no new word is taken
// until the last result of the word is in the output register.
// A finished result waits in the output register while the next word is
// taken; a stalled receiver holds the next result's column reads back.
// Reset clears counters and loads the default geometry and weights; the
// line buffers hold undefined data until written.
module gaussian_blur_7x7_reflect_top import gbr_pkg::*; #(
  parameter int unsigned MAX_WIDTH = 1024
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              s_axis_tvalid,
  output logic              s_axis_tready,
  input  logic [PIX_W-1:0]  s_axis_tdata,  // [7:0] pixel_in
  input  logic              s_axis_tuser,  // [0] op
  output logic              m_axis_tvalid,
  input  logic              m_axis_tready,
  output logic [PIX_W-1:0]  m_axis_tdata,  // [7:0] pixel_out
  output logic              m_axis_tlast,
  input  logic              cfg_valid_i,
  output logic              cfg_ready_o,
  input  logic [2:0]        cfg_index_i,
  input  logic [COEF_W-1:0] cfg_data_i
);

  localparam int unsigned CW = $clog2(MAX_WIDTH);
  localparam int unsigned DW = CW + 2;
  localparam logic [10:0] RST_WIDTH  = 11'd640;
  localparam logic [11:0] RST_HEIGHT = 12'd480;
  localparam logic [COEF_W-1:0] RST_COEF = 16'd9362;

  logic [10:0]            fw_q;
  logic [ROW_W-1:0]       fh_q;
  logic [3:0][COEF_W-1:0] coef_q;
  logic [CW:0]            w_eff;
  logic [ROW_W-1:0]       h_eff;
  logic [DW-1:0]          w1, w2, w3;

  state_e           state_q, state_d;
  logic [ROW_W-1:0] in_row_q, in_row_d;
  logic [CW-1:0]    in_col_q, in_col_d;
  logic [DW-1:0]    dpos_q, dpos_d;
  logic [ROW_W-1:0] job_r_q, job_r_d;
  logic [CW-1:0]    job_c_q, job_c_d;
  logic [2:0]       job_n_q, job_n_d;
  logic             job_eof_q, job_eof_d;
  logic [2:0]       step_q, step_d;
  logic             ovalid_q, ovalid_d;
  logic [PIX_W-1:0] odata_q, odata_d;
  logic             olast_q, olast_d;

  logic             acc_in;
  logic [ROW_W:0]   rr;
  logic [CW-1:0]    cc;
  logic [CW:0]      cn;
  logic             pix_new;
  logic             pix_res;
  logic             d1, d2, d3, deof;
  logic [DW-1:0]    dc, dnext;
  logic [ROW_W-1:0] drow;
  logic [ROW_W:0]   yp, ym;
  logic [CW+1:0]    xp, xm;
  logic [2:0]       wslot, pslot;
  logic             wclr, wadd, we;
  logic             iss_vld;
  logic [CW-1:0]    iss_addr;

  cell_ctl_t         ctl [WIN];
  logic              vld_c  [WIN+1];
  logic [CW-1:0]     addr_c [WIN];
  logic [VSUM_W-1:0] psum_c [WIN+1];
  logic              hacc_v;
  logic [PIX_W-1:0]  hacc_res;

  always_comb begin
    if (fw_q < 11'd4) begin
      w_eff = (CW+1)'(4);
    end else if (32'(fw_q) > 32'(MAX_WIDTH)) begin
      w_eff = (CW+1)'(MAX_WIDTH);
    end else begin
      w_eff = (CW+1)'(fw_q);
    end
    h_eff = (fh_q < 12'd4) ? 12'd4 : fh_q;
  end

  assign w1 = DW'(w_eff);
  assign w2 = w1 << 1;
  assign w3 = w1 + w2;

  assign cfg_ready_o = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fw_q   <= RST_WIDTH;
      fh_q   <= RST_HEIGHT;
      coef_q <= {4{RST_COEF}};
    end else if (cfg_valid_i) begin
      case (cfg_idx_e'(cfg_index_i))
        CFG_FRAME_WIDTH:  fw_q      <= cfg_data_i[10:0];
        CFG_FRAME_HEIGHT: fh_q      <= cfg_data_i[ROW_W-1:0];
        CFG_COEF_CENTER:  coef_q[0] <= cfg_data_i;
        CFG_COEF_ONE:     coef_q[1] <= cfg_data_i;
        CFG_COEF_TWO:     coef_q[2] <= cfg_data_i;
        CFG_COEF_THREE:   coef_q[3] <= cfg_data_i;
        default: ;
      endcase
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign acc_in        = s_axis_tvalid && s_axis_tready;

  always_comb begin
    rr      = {1'b0, in_row_q};
    cc      = in_col_q;
    pix_new = 1'b0;
    if ({1'b0, in_col_q} >= w_eff) begin
      cc = '0;
      rr = rr + 1'b1;
    end
    if (rr >= (ROW_W+1)'(h_eff)) begin
      rr      = '0;
      cc      = '0;
      pix_new = 1'b1;
    end
    cn      = {1'b0, cc} + 1'b1;
    pix_res = (rr >= (ROW_W+1)'(HALF)) && (cc >= CW'(HALF));
    wslot   = mod7(rr[ROW_W-1:0]);

    d1    = dpos_q >= w1;
    d2    = dpos_q >= w2;
    d3    = dpos_q >= w3;
    dc    = d2 ? dpos_q - w2 : (d1 ? dpos_q - w1 : dpos_q);
    drow  = h_eff - ROW_W'(HALF) + (d2 ? 12'd2 : (d1 ? 12'd1 : 12'd0));
    dnext = dpos_q + 1'b1;
    deof  = dnext == w3;

    yp = {1'b0, job_r_q} + (ROW_W+1)'(step_q);
    if (yp < (ROW_W+1)'(HALF)) begin
      ym = (ROW_W+1)'(HALF - 1) - yp;
    end else begin
      ym = yp - (ROW_W+1)'(HALF);
      if (ym >= (ROW_W+1)'(h_eff)) begin
        ym = ((ROW_W+1)'(h_eff) << 1) - 1'b1 - ym;
      end
    end
    pslot = mod7(ym[ROW_W-1:0]);

    xp = (CW+2)'(job_c_q) + (CW+2)'(step_q);
    if (xp < (CW+2)'(HALF)) begin
      xm = (CW+2)'(HALF - 1) - xp;
    end else begin
      xm = xp - (CW+2)'(HALF);
      if (xm >= (CW+2)'(w_eff)) begin
        xm = ((CW+2)'(w_eff) << 1) - 1'b1 - xm;
      end
    end
    iss_addr = xm[CW-1:0];
  end

  always_comb begin
    state_d   = state_q;
    in_row_d  = in_row_q;
    in_col_d  = in_col_q;
    dpos_d    = dpos_q;
    job_r_d   = job_r_q;
    job_c_d   = job_c_q;
    job_n_d   = job_n_q;
    job_eof_d = job_eof_q;
    step_d    = step_q;
    ovalid_d  = ovalid_q && !m_axis_tready;
    odata_d   = odata_q;
    olast_d   = olast_q;
    wclr      = 1'b0;
    wadd      = 1'b0;
    we        = 1'b0;
    iss_vld   = 1'b0;
    case (state_q)
      ST_IDLE: begin
        if (acc_in) begin
          if (!s_axis_tuser) begin
            we = 1'b1;
            if (pix_new) begin
              dpos_d = '0;
            end
            if (cn >= w_eff) begin
              in_col_d = '0;
              in_row_d = ROW_W'(rr + 1'b1);
            end else begin
              in_col_d = CW'(cn);
              in_row_d = ROW_W'(rr);
            end
            if (pix_res) begin
              job_r_d   = ROW_W'(rr - (ROW_W+1)'(HALF));
              job_c_d   = cc - CW'(HALF);
              job_n_d   = ({1'b0, cc} == w_eff - 1'b1) ? 3'd4 : 3'd1;
              job_eof_d = 1'b0;
              wclr      = 1'b1;
              step_d    = '0;
              state_d   = ST_WGT;
            end
          end else if (in_row_q >= h_eff) begin
            if (d3) begin
              in_row_d = '0;
              in_col_d = '0;
              dpos_d   = '0;
            end else begin
              job_r_d   = drow;
              job_c_d   = CW'(dc);
              job_n_d   = 3'd1;
              job_eof_d = deof;
              dpos_d    = deof ? '0 : dnext;
              if (deof) begin
                in_row_d = '0;
                in_col_d = '0;
              end
              wclr    = 1'b1;
              step_d  = '0;
              state_d = ST_WGT;
            end
          end
        end
      end
      ST_WGT: begin
        wadd = 1'b1;
        if (step_q == 3'(WIN - 1)) begin
          step_d  = '0;
          state_d = ST_ISSUE;
        end else begin
          step_d = step_q + 1'b1;
        end
      end
      ST_ISSUE: begin
        if (step_q != 3'd0 || !ovalid_q) begin
          iss_vld = 1'b1;
          if (step_q == 3'(WIN - 1)) begin
            step_d  = '0;
            state_d = ST_WAIT;
          end else begin
            step_d = step_q + 1'b1;
          end
        end
      end
      ST_WAIT: begin
        if (hacc_v) begin
          ovalid_d = 1'b1;
          odata_d  = hacc_res;
          olast_d  = job_eof_q && (job_n_q == 3'd1);
          job_n_d  = job_n_q - 1'b1;
          job_c_d  = job_c_q + 1'b1;
          state_d  = (job_n_q == 3'd1) ? ST_IDLE : ST_ISSUE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_row_q <= '0;
      in_col_q <= '0;
      dpos_q   <= '0;
      job_n_q  <= '0;
      step_q   <= '0;
      ovalid_q <= 1'b0;
    end else begin
      in_row_q <= in_row_d;
      in_col_q <= in_col_d;
      dpos_q   <= dpos_d;
      job_n_q  <= job_n_d;
      step_q   <= step_d;
      ovalid_q <= ovalid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    job_r_q   <= job_r_d;
    job_c_q   <= job_c_d;
    job_eof_q <= job_eof_d;
    odata_q   <= odata_d;
    olast_q   <= olast_d;
  end

  always_comb begin
    for (int k = 0; k < WIN; k++) begin
      ctl[k].wclr  = wclr;
      ctl[k].wadd  = wadd && (pslot == 3'(k));
      ctl[k].wval  = coef_q[tap_ofs(step_q)];
      ctl[k].we    = we && (wslot == 3'(k));
      ctl[k].wdata = s_axis_tdata;
    end
  end

  assign vld_c[0]  = iss_vld;
  assign addr_c[0] = iss_addr;
  assign psum_c[0] = '0;

  for (genvar k = 0; k < WIN; k++) begin : g_cell
    if (k < WIN - 1) begin : g_mid
      gbr_cell #(
        .MAX_WIDTH(MAX_WIDTH)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl[k]),
        .waddr_i(cc),
        .vld_i  (vld_c[k]),
        .addr_i (addr_c[k]),
        .psum_i (psum_c[k]),
        .vld_o  (vld_c[k+1]),
        .addr_o (addr_c[k+1]),
        .psum_o (psum_c[k+1])
      );
    end else begin : g_end
      gbr_cell #(
        .MAX_WIDTH(MAX_WIDTH)
      ) u_cell (
        .clk_i  (clk_i),
        .rst_ni (rst_ni),
        .ctl_i  (ctl[k]),
        .waddr_i(cc),
        .vld_i  (vld_c[k]),
        .addr_i (addr_c[k]),
        .psum_i (psum_c[k]),
        .vld_o  (vld_c[k+1]),
        .addr_o (),
        .psum_o (psum_c[k+1])
      );
    end
  end

  gbr_hacc u_hacc (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .vld_i    (vld_c[WIN]),
    .vsum_i   (psum_c[WIN]),
    .coef_i   (coef_q),
    .res_vld_o(hacc_v),
    .res_o    (hacc_res)
  );

  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tdata  = odata_q;
  assign m_axis_tlast  = olast_q;

`ifndef SYNTHESIS
  a_res_slot_free: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hacc_v |-> !ovalid_q)
    else $error("result arrived while output register full");
  a_res_in_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    hacc_v |-> state_q == ST_WAIT)
    else $error("result arrived outside wait state");
  a_job_pending: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_ISSUE || state_q == ST_WAIT) |-> job_n_q != 3'd0)
    else $error("column reads without a pending result");
`endif

endmodule
